// ----- hw/rtl/assert_macros.svh -----
// Assertion macros included by the top-level RTL file of the peak period detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define PPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/ppd_pkg.sv -----
// Package with widths, codes and types of the peak period detector.
package ppd_pkg;

  localparam int TIME_W  = 32;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 12;
  localparam int SUM_W   = TIME_W + COUNT_W;
  localparam int ALU_W   = SUM_W + 1;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  // Configuration port.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_LIMIT = 1'b0;
  localparam logic [COUNT_W-1:0] PEAK_LIMIT_RST = 12'd64;

  // Sign bit of a sample value, flipped to turn a signed order into an unsigned one.
  localparam logic [VALUE_W-1:0] VALUE_SIGN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_RISE = 2'd1,
    PH_FALL = 2'd2
  } phase_t;

  // Request to and response from the shared add/subtract unit.
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             neg;
  } alu_rsp_t;

endpackage

// ----- hw/rtl/ppd_in_if.sv -----
// Input channel carrying one timed sample per transaction.
interface ppd_in_if
  import ppd_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic        [TIME_W-1:0]  sample_time;
  logic signed [VALUE_W-1:0] sample_value;
  logic                      last_sample;

  modport source (output valid, sample_time, sample_value, last_sample, input ready);
  modport sink   (input valid, sample_time, sample_value, last_sample, output ready);
endinterface

// ----- hw/rtl/ppd_out_if.sv -----
// Result channel carrying one period or mean result per transaction.
interface ppd_out_if
  import ppd_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  result_value;
  logic               is_mean;
  logic [COUNT_W-1:0] period_count;
  logic               no_periods;
  logic               last;

  modport source (output valid, result_value, is_mean, period_count, no_periods, last,
                  input ready);
  modport sink   (input valid, result_value, is_mean, period_count, no_periods, last,
                  output ready);
endinterface

// ----- hw/rtl/ppd_alu.sv -----
// Shared add/subtract unit used for compares, period, sum and division steps.
module ppd_alu
  import ppd_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [ALU_W-1:0] b_op;

  // Subtraction is addition of the inverted operand plus one.
  assign b_op    = req.sub ? ~req.b : req.b;
  assign rsp.sum = req.a + b_op + {{(ALU_W-1){1'b0}}, req.sub};
  // Operands stay below half the range, so the top bit flags a negative difference.
  assign rsp.neg = rsp.sum[ALU_W-1];

endmodule

// ----- hw/rtl/ppd_seq.sv -----
// Sequencer and state of the peak period detector around the shared unit.
module ppd_seq
  import ppd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [COUNT_W-1:0] peak_limit,
  ppd_in_if.sink             in_chan,
  ppd_out_if.source          out_chan
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CMP  = 7'b0000010,
    S_PER  = 7'b0000100,
    S_SUM  = 7'b0001000,
    S_FIN  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_MEAN = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Sample held for the duration of its processing.
  logic [TIME_W-1:0]  t_r;
  logic [VALUE_W-1:0] v_r;
  logic               last_r;

  // Detector state.
  phase_t             phase_r;
  logic [VALUE_W-1:0] level_r;
  logic [TIME_W-1:0]  prev_time_r;
  logic               have_peak_r;
  logic [TIME_W-1:0]  peak_time_r;
  logic [COUNT_W-1:0] pairs_done_r;
  logic [SUM_W-1:0]   period_sum_r;
  logic [COUNT_W-1:0] periods_seen_r;
  logic [TIME_W-1:0]  p_r;

  // Divider state.
  logic [SUM_W-1:0]     quo_r;
  logic [COUNT_W-1:0]   rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  // Output register.
  logic               out_valid_r;
  logic [TIME_W-1:0]  out_value_r;
  logic               out_mean_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_none_r;

  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  logic             out_free;
  logic             limit_ok;
  logic             no_period;
  logic             clear_stream;
  logic             load_out;
  logic [COUNT_W:0] trial;

  ppd_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign out_free  = !out_valid_r || out_chan.ready;
  assign limit_ok  = pairs_done_r < peak_limit;
  assign no_period = periods_seen_r == '0;
  assign trial     = {rem_r, quo_r[SUM_W-1]};

  // The stream ends when its mean result enters the output register.
  assign clear_stream = out_free &&
                        (((state_r == S_FIN) && last_r && no_period) ||
                         (state_r == S_MEAN));

  // A period or a mean result enters the output register.
  assign load_out = ((state_r == S_PER) && out_free) || clear_stream;

  // Operand selection for the shared unit.
  always_comb begin
    alu_req = '0;
    unique case (state_r)
      S_CMP: begin
        alu_req.sub = 1'b1;
        if (phase_r == PH_RISE) begin
          alu_req.a = {{(ALU_W-VALUE_W){1'b0}}, level_r ^ VALUE_SIGN};
          alu_req.b = {{(ALU_W-VALUE_W){1'b0}}, v_r ^ VALUE_SIGN};
        end else begin
          alu_req.a = {{(ALU_W-VALUE_W){1'b0}}, v_r ^ VALUE_SIGN};
          alu_req.b = {{(ALU_W-VALUE_W){1'b0}}, level_r ^ VALUE_SIGN};
        end
      end
      S_PER: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {{(ALU_W-TIME_W){1'b0}}, prev_time_r};
        alu_req.b   = {{(ALU_W-TIME_W){1'b0}}, peak_time_r};
      end
      S_SUM: begin
        alu_req.a = {1'b0, period_sum_r};
        alu_req.b = {{(ALU_W-TIME_W){1'b0}}, p_r};
      end
      S_DIV: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {{(ALU_W-COUNT_W-1){1'b0}}, trial};
        alu_req.b   = {{(ALU_W-COUNT_W){1'b0}}, periods_seen_r};
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_chan.valid) state_nxt = S_CMP;
      S_CMP: begin
        if (phase_r == PH_RISE && limit_ok && !alu_rsp.neg && have_peak_r) begin
          state_nxt = S_PER;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_PER: if (out_free) state_nxt = S_SUM;
      S_SUM: state_nxt = S_FIN;
      S_FIN: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (no_period) begin
          if (out_free) state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: if (div_cnt_r == DIV_CNT_W'(1)) state_nxt = S_MEAN;
      S_MEAN: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers and detector state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      phase_r        <= PH_WAIT;
      level_r        <= '0;
      prev_time_r    <= '0;
      have_peak_r    <= 1'b0;
      peak_time_r    <= '0;
      pairs_done_r   <= '0;
      period_sum_r   <= '0;
      periods_seen_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CMP: begin
          unique case (phase_r)
            PH_WAIT: begin
              phase_r <= PH_RISE;
              level_r <= '0;
            end
            PH_RISE: begin
              if (limit_ok) begin
                if (alu_rsp.neg) begin
                  level_r <= v_r;
                end else if (!have_peak_r) begin
                  // First peak: no period yet.
                  peak_time_r <= prev_time_r;
                  have_peak_r <= 1'b1;
                  phase_r     <= PH_FALL;
                end
              end
            end
            default: begin
              // Falling: a sample that is not smaller closes one pair.
              if (alu_rsp.neg) begin
                level_r <= v_r;
              end else begin
                if (pairs_done_r != '1) pairs_done_r <= pairs_done_r + 1'b1;
                phase_r <= PH_RISE;
              end
            end
          endcase
        end
        S_PER: begin
          if (out_free) begin
            peak_time_r <= prev_time_r;
            have_peak_r <= 1'b1;
            phase_r     <= PH_FALL;
            if (periods_seen_r != '1) periods_seen_r <= periods_seen_r + 1'b1;
          end
        end
        S_SUM: period_sum_r <= alu_rsp.sum[SUM_W-1:0];
        S_FIN: if (!last_r) prev_time_r <= t_r;
        default: ;
      endcase

      if (clear_stream) begin
        phase_r        <= PH_WAIT;
        level_r        <= '0;
        prev_time_r    <= '0;
        have_peak_r    <= 1'b0;
        peak_time_r    <= '0;
        pairs_done_r   <= '0;
        period_sum_r   <= '0;
        periods_seen_r <= '0;
      end
    end
  end

  // Payload registers: sample latch, divider and result.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_chan.valid) begin
      t_r    <= in_chan.sample_time;
      v_r    <= in_chan.sample_value;
      last_r <= in_chan.last_sample;
    end

    if (state_r == S_PER && out_free) begin
      p_r         <= alu_rsp.sum[TIME_W-1:0];
      out_value_r <= alu_rsp.sum[TIME_W-1:0];
      out_mean_r  <= 1'b0;
      out_count_r <= '0;
      out_none_r  <= 1'b0;
    end

    // Restoring division of the period sum, one quotient bit a cycle.
    if (state_r == S_FIN) begin
      quo_r     <= period_sum_r;
      rem_r     <= '0;
      div_cnt_r <= DIV_CNT_W'(SUM_W);
    end
    if (state_r == S_DIV) begin
      rem_r     <= alu_rsp.neg ? trial[COUNT_W-1:0] : alu_rsp.sum[COUNT_W-1:0];
      quo_r     <= {quo_r[SUM_W-2:0], !alu_rsp.neg};
      div_cnt_r <= div_cnt_r - 1'b1;
    end

    if (clear_stream) begin
      out_value_r <= (state_r == S_MEAN) ? quo_r[TIME_W-1:0] : '0;
      out_mean_r  <= 1'b1;
      out_count_r <= periods_seen_r;
      out_none_r  <= no_period;
    end
  end

  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_value = out_value_r;
  assign out_chan.is_mean      = out_mean_r;
  assign out_chan.period_count = out_count_r;
  assign out_chan.no_periods   = out_none_r;
  assign out_chan.last         = out_mean_r;

endmodule

// ----- hw/rtl/peak_period_detector.sv -----
// Top level: peak period detector with its configuration register.
// A sample is accepted, compared and finished, and when it closes a period it is also
// subtracted and accumulated, all through the one shared add/subtract unit.
// A last sample with periods found adds a restoring division and a final state
// to load the mean; a sample with a result to emit waits while the output register is full.
// Synchronous active-low reset clears the detector state, empties the output
// register and sets peak_limit to 64.
module peak_period_detector
  import ppd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  ppd_in_if.sink                in_chan,
  ppd_out_if.source             out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  `include "assert_macros.svh"

  logic [COUNT_W-1:0] peak_limit_r;
  logic               hit_limit;

  assign pready    = 1'b1;
  assign hit_limit = paddr[CFG_ADDR_W-1:2] == REG_PEAK_LIMIT;

  // Configuration register write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_limit_r <= PEAK_LIMIT_RST;
    end else if (psel && penable && pwrite && pready && hit_limit) begin
      peak_limit_r <= pwdata[COUNT_W-1:0];
    end
  end

  // Register read back.
  assign prdata = hit_limit ? {{(CFG_DATA_W-COUNT_W){1'b0}}, peak_limit_r} : '0;

  ppd_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .peak_limit (peak_limit_r),
    .in_chan    (in_chan),
    .out_chan   (out_chan)
  );

  `PPD_ASSERT(a_busy_after_accept, (in_chan.valid && in_chan.ready) |=> !in_chan.ready, "input accepted on consecutive cycles")
  `PPD_ASSERT(a_mean_is_last, out_chan.valid |-> (out_chan.is_mean == out_chan.last), "mean result and last flag disagree")
  `PPD_ASSERT(a_no_periods_form, (out_chan.valid && out_chan.no_periods) |-> (out_chan.is_mean && out_chan.period_count == '0 && out_chan.result_value == '0), "malformed empty mean result")
  `PPD_ASSERT_ALWAYS(a_reset_empty, $past(!rst_n) |-> !out_chan.valid, "result valid right after reset")

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the peak period detector with a scoreboard and random streams.
module testbench;
  import ppd_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int IDLE_WAIT   = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int LONG_STREAM = 200;
  localparam int CYCLE_LIMIT = 4000000;
  localparam logic [VALUE_W-1:0] VALUE_MIN = VALUE_SIGN;
  localparam logic [VALUE_W-1:0] VALUE_MAX = ~VALUE_SIGN;

  typedef enum int {
    STREAM_WAVE,
    STREAM_NOISE,
    STREAM_TIES
  } stream_kind_t;

  typedef struct {
    logic [TIME_W-1:0]         sample_time;
    logic signed [VALUE_W-1:0] sample_value;
    logic                      last_sample;
  } sample_t;

  typedef struct {
    logic [TIME_W-1:0]  result_value;
    logic               is_mean;
    logic [COUNT_W-1:0] period_count;
    logic               no_periods;
    logic               last;
  } period_result_t;

  // Tracks peaks and periods of the stream and holds the results still to come.
  class period_scoreboard;
    bit [COUNT_W-1:0]        peak_limit;
    phase_t                  phase;
    bit signed [VALUE_W-1:0] level;
    bit [TIME_W-1:0]         prev_time;
    bit [TIME_W-1:0]         peak_time;
    bit                      have_peak;
    bit [COUNT_W-1:0]        pairs_done;
    bit [COUNT_W-1:0]        periods_seen;
    bit [SUM_W-1:0]          period_sum;
    period_result_t          expected_q[$];
    int                      errors;

    function new();
      errors     = 0;
      peak_limit = PEAK_LIMIT_RST;
      clear_stream();
    endfunction

    function void clear_stream();
      phase        = PH_WAIT;
      level        = '0;
      prev_time    = '0;
      have_peak    = 1'b0;
      peak_time    = '0;
      pairs_done   = '0;
      periods_seen = '0;
      period_sum   = '0;
    endfunction

    function void set_limit(bit [COUNT_W-1:0] lim);
      peak_limit = lim;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endfunction

    function void push_result(bit [TIME_W-1:0] value, bit mean, bit [COUNT_W-1:0] count,
                              bit none, bit lst);
      period_result_t r;
      r.result_value = value;
      r.is_mean      = mean;
      r.period_count = count;
      r.no_periods   = none;
      r.last         = lst;
      expected_q.push_back(r);
    endfunction

    // Advance the detector by one accepted sample and queue what it emits.
    function void note_sample(sample_t s);
      bit [TIME_W-1:0] period;
      bit [SUM_W-1:0]  quotient;
      case (phase)
        PH_WAIT: begin
          phase = PH_RISE;
          level = '0;
        end
        PH_RISE: begin
          // Once the pair limit is reached only the time is kept.
          if (pairs_done < peak_limit) begin
            if (s.sample_value > level) begin
              level = s.sample_value;
            end else begin
              // The previous sample was a peak.
              if (have_peak) begin
                period = prev_time - peak_time;
                push_result(period, 1'b0, '0, 1'b0, 1'b0);
                period_sum = period_sum + SUM_W'(period);
                if (periods_seen != '1) periods_seen++;
              end
              peak_time = prev_time;
              have_peak = 1'b1;
              phase     = PH_FALL;
            end
          end
        end
        default: begin
          if (s.sample_value < level) begin
            level = s.sample_value;
          end else begin
            if (pairs_done != '1) pairs_done++;
            phase = PH_RISE;
          end
        end
      endcase
      prev_time = s.sample_time;

      // The final sample closes the stream with the truncated mean.
      if (s.last_sample) begin
        if (periods_seen == 0) begin
          push_result('0, 1'b1, '0, 1'b1, 1'b1);
        end else begin
          quotient = period_sum / periods_seen;
          push_result(quotient[TIME_W-1:0], 1'b1, periods_seen, 1'b0, 1'b1);
        end
        clear_stream();
      end
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(period_result_t got);
      period_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0h with nothing expected", got.result_value));
        return;
      end
      want = expected_q.pop_front();
      if (got.result_value !== want.result_value)
        report($sformatf("result_value %0h, expected %0h", got.result_value,
                         want.result_value));
      if (got.is_mean !== want.is_mean)
        report($sformatf("is_mean %0b, expected %0b", got.is_mean, want.is_mean));
      if (got.period_count !== want.period_count)
        report($sformatf("period_count %0d, expected %0d", got.period_count,
                         want.period_count));
      if (got.no_periods !== want.no_periods)
        report($sformatf("no_periods %0b, expected %0b", got.no_periods, want.no_periods));
      if (got.last !== want.last)
        report($sformatf("last %0b, expected %0b", got.last, want.last));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  period_scoreboard sb;
  logic             out_fire;
  bit               hold_req;
  bit               tx_burst;
  int               cycle_count;

  ppd_in_if  in_chan ();
  ppd_out_if out_chan ();

  peak_period_detector u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("peak_period_detector test failed");
    $finish;
  end

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    period_result_t got;
    sample_t        seen;
    out_fire = rst_n && out_chan.valid && out_chan.ready;
    if (out_fire) begin
      got.result_value = out_chan.result_value;
      got.is_mean      = out_chan.is_mean;
      got.period_count = out_chan.period_count;
      got.no_periods   = out_chan.no_periods;
      got.last         = out_chan.last;
      sb.check_result(got);
    end
    if (rst_n && in_chan.valid && in_chan.ready) begin
      seen.sample_time  = in_chan.sample_time;
      seen.sample_value = in_chan.sample_value;
      seen.last_sample  = in_chan.last_sample;
      sb.note_sample(seen);
    end
  end

  // Result receiver: random stalls, runs without stalls, and one long hold-off on request.
  initial begin
    int stall;
    int burst_left;
    int hold_left;
    stall          = 0;
    burst_left     = 0;
    hold_left      = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (out_fire) begin
        if (burst_left > 0) begin
          burst_left--;
          stall = 0;
        end else if ($urandom_range(0, 5) == 0) begin
          burst_left = 30;
          stall      = 0;
        end else begin
          stall = $urandom_range(0, 19);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Offer one sample after a random gap (none in burst mode) and return at the falling edge after its transaction.
  task automatic send_sample(input logic [TIME_W-1:0] t, input logic [VALUE_W-1:0] v,
                             input logic lst);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.sample_time  <= t;
    in_chan.sample_value <= v;
    in_chan.last_sample  <= lst;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write peak_limit once the detector is idle, then read it back.
  task automatic set_peak_limit(input logic [COUNT_W-1:0] lim);
    logic [CFG_ADDR_W-1:0] addr;
    addr = {REG_PEAK_LIMIT, 2'b00};
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= CFG_DATA_W'(lim);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== CFG_DATA_W'(lim))
      sb.report($sformatf("peak_limit reads back %0h, written %0h", prdata, lim));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_limit(lim);
  endtask

  // One stream of samples with a given shape, closed by the final-sample flag.
  task automatic send_stream(input stream_kind_t kind, input int len);
    logic [TIME_W-1:0]         t;
    logic signed [VALUE_W-1:0] v;
    logic [VALUE_W-1:0]        step;
    bit                        down;
    t        = $urandom;
    v        = $urandom;
    down     = 1'($urandom_range(0, 1));
    tx_burst = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < len; k++) begin
      case (kind)
        STREAM_WAVE: begin
          if ($urandom_range(0, 3) == 0) down = !down;
          step = ($urandom_range(0, 7) == 0) ? '0 : ($urandom >> $urandom_range(3, 31));
          v    = down ? v - step : v + step;
        end
        STREAM_NOISE: begin
          v = $urandom;
        end
        default: begin
          case ($urandom_range(0, 4))
            0:       v = VALUE_MIN;
            1:       v = VALUE_MAX;
            2:       v = -32'sd1;
            3:       v = 32'sd1;
            default: v = '0;
          endcase
        end
      endcase
      send_sample(t, v, k == len - 1);
      // Mostly forward steps of varied size, now and then a jump anywhere.
      if ($urandom_range(0, 15) == 0) t = $urandom;
      else t = t + ($urandom >> $urandom_range(8, 31));
    end
  endtask

  // Random streams: mostly oscillating waves, some tie-heavy, some noise and short ones.
  task automatic run_streams(input int budget, input int max_len);
    int           sent;
    int           len;
    int           pick;
    stream_kind_t kind;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 9);
      kind = (pick < 6) ? STREAM_WAVE : ((pick < 8) ? STREAM_TIES : STREAM_NOISE);
      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, max_len);
      send_stream(kind, len);
      sent += len;
    end
  endtask

  // Main sequence.
  initial begin
    logic [TIME_W-1:0] long_time;
    sb                   = new();
    hold_req             = 1'b0;
    tx_burst             = 1'b0;
    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_chan.valid        = 1'b0;
    in_chan.sample_time  = '0;
    in_chan.sample_value = '0;
    in_chan.last_sample  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed streams at the reset limit.
    // A stream of one sample has no period.
    send_sample(32'hFFFF_FFFF, VALUE_MIN, 1'b1);
    // Extremes, ties, times going backwards, and a last sample failing to rise.
    send_sample(32'd0, '0, 1'b0);
    send_sample(32'd100, VALUE_MAX, 1'b0);
    send_sample(32'd200, VALUE_MAX, 1'b0);
    send_sample(32'd300, VALUE_MIN, 1'b0);
    send_sample(32'd400, VALUE_MIN, 1'b0);
    send_sample(32'd50, VALUE_MIN, 1'b0);
    send_sample(32'd60, '0, 1'b0);
    send_sample(32'd70, 32'sd5, 1'b0);
    send_sample(32'd80, 32'sd5, 1'b1);
    // Last sample still rising.
    send_sample(32'd1, '0, 1'b0);
    send_sample(32'd2, 32'sd1, 1'b0);
    send_sample(32'd3, 32'sd2, 1'b1);
    // Last sample still falling, after a single peak.
    send_sample(32'd0, '0, 1'b0);
    send_sample(32'd10, -32'sd1, 1'b0);
    send_sample(32'd20, -32'sd2, 1'b1);

    // Smallest limit: one pair, so never a period.
    set_peak_limit(12'd1);
    run_streams(200, 24);

    // Largest limit, with one long stream of ties sent back to back.
    set_peak_limit(12'd4095);
    tx_burst  = 1'b1;
    long_time = $urandom;
    for (int k = 0; k < LONG_STREAM; k++) begin
      send_sample(long_time, '0, k == LONG_STREAM - 1);
      long_time = long_time + $urandom;
    end
    run_streams(250, 40);

    set_peak_limit(12'd2);
    run_streams(200, 24);

    // The receiver holds off for a while here, so the detector backs up.
    set_peak_limit(COUNT_W'($urandom_range(3, 200)));
    hold_req = 1'b1;
    run_streams(350, 40);

    set_peak_limit(PEAK_LIMIT_RST);
    run_streams(350, 40);

    // Drain and let the block settle.
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
    if (sb.errors == 0) begin
      $display("peak_period_detector test passed");
    end else begin
      $display("peak_period_detector test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/ppd_pkg.sv
hw/rtl/ppd_in_if.sv
hw/rtl/ppd_out_if.sv
hw/rtl/ppd_alu.sv
hw/rtl/ppd_seq.sv
hw/rtl/peak_period_detector.sv
test/testbench.sv
